// ----- design/lsbb_pkg.sv -----
`default_nettype none

package lsbb_pkg;

    // Default duty resolution (full duty is 2^DUTY_BITS - 1)
    localparam int DUTY_BITS_DEF = 13;

    // Field and register widths
    localparam int DUTY_OUT_W = 14;
    localparam int STATUS_W   = 3;
    localparam int PERIOD_W   = 12;
    localparam int RSTEP_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Breathe ramp increment
    localparam int RAMP_INC = 64;

    // Register reset values
    localparam logic [PERIOD_W-1:0] IDLE_PERIOD_RST  = 12'd1000;
    localparam logic [PERIOD_W-1:0] MAINT_PERIOD_RST = 12'd3000;
    localparam logic [PERIOD_W-1:0] ACT_PERIOD_RST   = 12'd500;
    localparam logic [PERIOD_W-1:0] WORK_PERIOD_RST  = 12'd100;
    localparam logic [RSTEP_W-1:0]  RAMP_STEP_RST    = 8'd20;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_PERIOD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAINT_PERIOD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACT_PERIOD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WORK_PERIOD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP    = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_IDLE     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MAINT    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ACTIVE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_WORKING  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SLEEPING = 3'd4;

    // Item kinds
    localparam logic MODE_TICK   = 1'b0;
    localparam logic MODE_STATUS = 1'b1;

    // Running effect, one-hot
    typedef enum logic [2:0] {
        FX_NONE    = 3'b001,
        FX_BLINK   = 3'b010,
        FX_BREATHE = 3'b100
    } t_effect;

endpackage

`default_nettype wire

// ----- design/led_status_blink_breathe.sv -----
`default_nettype none

// Status LED duty generator. Each transfer on the input channel is either a
// one-millisecond tick or a new status; each one yields exactly one result
// (duty level and a written flag) on the output channel in the next cycle.
// The block takes one item per clock: all the work for an item is a single
// pass of counter, compare and select logic into the state and result
// registers, so the sustained rate is one item per cycle as long as the
// output side takes results. When the output side stalls with a result
// waiting, the input stall follows it in the same cycle. Blink periods and
// the ramp step are read live on every tick; write them only while idle.
module led_status_blink_breathe #(
    parameter int DUTY_BITS = lsbb_pkg::DUTY_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // input channel
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic                              i_mode,
    input  wire logic [lsbb_pkg::STATUS_W-1:0]     i_status_code,
    // output channel
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [lsbb_pkg::DUTY_OUT_W-1:0]        o_duty_level,
    output logic                                   o_duty_written,
    // configuration
    input  wire logic                              i_cfg_we,
    input  wire logic [lsbb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [lsbb_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int RAMP_W = DUTY_BITS + 1;
    localparam int EXT_W  = (RAMP_W > lsbb_pkg::DUTY_OUT_W) ? RAMP_W : lsbb_pkg::DUTY_OUT_W;
    localparam int PW     = lsbb_pkg::PERIOD_W;

    localparam logic [DUTY_BITS-1:0] DUTY_FULL = {DUTY_BITS{1'b1}};
    localparam logic [DUTY_BITS-1:0] DUTY_QTR  = DUTY_FULL >> 2;
    localparam logic [DUTY_BITS-1:0] DUTY_HALF = DUTY_FULL >> 1;
    localparam logic [RAMP_W-1:0]    RAMP_MAX  = {1'b0, DUTY_FULL};
    localparam logic [RAMP_W-1:0]    RAMP_INC  = RAMP_W'(lsbb_pkg::RAMP_INC);

    // configuration registers
    logic [PW-1:0]                   r_idle_period;
    logic [PW-1:0]                   r_maint_period;
    logic [PW-1:0]                   r_act_period;
    logic [PW-1:0]                   r_work_period;
    logic [lsbb_pkg::RSTEP_W-1:0]    r_ramp_step;

    // effect state
    logic [lsbb_pkg::STATUS_W-1:0]   r_status,     n_status;
    lsbb_pkg::t_effect               r_effect,     n_effect;
    logic                            r_lit,        n_lit;
    logic [PW-1:0]                   r_tick,       n_tick;
    logic [RAMP_W-1:0]               r_ramp_level, n_ramp_level;
    logic                            r_ramp_rise,  n_ramp_rise;
    logic [lsbb_pkg::DUTY_OUT_W-1:0] r_held,       n_held;
    logic                            r_written,    n_written;
    logic                            r_out_valid;

    logic                            accept;
    logic [PW-1:0]                   blink_period;
    logic [DUTY_BITS-1:0]            blink_duty;
    logic [PW-1:0]                   tick_period;
    logic [PW-1:0]                   tick_inc;
    logic                            tick_fire;
    logic [RAMP_W-1:0]               adv_base;
    logic                            adv_base_rise;
    logic [RAMP_W-1:0]               adv_level;
    logic                            adv_rise;

    assign o_in_stall     = r_out_valid && i_out_stall;
    assign accept         = i_in_valid && !o_in_stall;
    assign o_out_valid    = r_out_valid;
    assign o_duty_level   = r_held;
    assign o_duty_written = r_written;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_period  <= lsbb_pkg::IDLE_PERIOD_RST;
            r_maint_period <= lsbb_pkg::MAINT_PERIOD_RST;
            r_act_period   <= lsbb_pkg::ACT_PERIOD_RST;
            r_work_period  <= lsbb_pkg::WORK_PERIOD_RST;
            r_ramp_step    <= lsbb_pkg::RAMP_STEP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lsbb_pkg::REG_IDLE_PERIOD:  r_idle_period  <= i_cfg_data;
                lsbb_pkg::REG_MAINT_PERIOD: r_maint_period <= i_cfg_data;
                lsbb_pkg::REG_ACT_PERIOD:   r_act_period   <= i_cfg_data;
                lsbb_pkg::REG_WORK_PERIOD:  r_work_period  <= i_cfg_data;
                lsbb_pkg::REG_RAMP_STEP:    r_ramp_step    <= i_cfg_data[lsbb_pkg::RSTEP_W-1:0];
                default: ;
            endcase
        end
    end

    // per-status blink half-period and lit duty
    always_comb begin
        case (r_status)
            lsbb_pkg::ST_IDLE:    blink_period = r_idle_period;
            lsbb_pkg::ST_MAINT:   blink_period = r_maint_period;
            lsbb_pkg::ST_ACTIVE:  blink_period = r_act_period;
            lsbb_pkg::ST_WORKING: blink_period = r_work_period;
            default:              blink_period = r_idle_period;
        endcase
        case (r_status)
            lsbb_pkg::ST_IDLE:  blink_duty = DUTY_QTR;
            lsbb_pkg::ST_MAINT: blink_duty = DUTY_HALF;
            default:            blink_duty = DUTY_FULL;
        endcase
    end

    // tick counter: wraps at 12 bits, fires at or past the period
    assign tick_period = (r_effect == lsbb_pkg::FX_BREATHE) ? PW'(r_ramp_step) : blink_period;
    assign tick_inc    = r_tick + 1'b1;
    assign tick_fire   = (tick_inc >= tick_period);

    // ramp step; a new sleeping status restarts from zero, rising
    assign adv_base      = (i_mode == lsbb_pkg::MODE_STATUS) ? '0 : r_ramp_level;
    assign adv_base_rise = (i_mode == lsbb_pkg::MODE_STATUS) ? 1'b1 : r_ramp_rise;

    always_comb begin
        if (adv_base_rise) begin
            adv_level = adv_base + RAMP_INC;
            adv_rise  = !(adv_level >= RAMP_MAX);
        end else begin
            adv_level = adv_base - RAMP_INC;
            adv_rise  = (adv_level == '0);
        end
    end

    // next state for one item
    always_comb begin
        n_status     = r_status;
        n_effect     = r_effect;
        n_lit        = r_lit;
        n_tick       = r_tick;
        n_ramp_level = r_ramp_level;
        n_ramp_rise  = r_ramp_rise;
        n_held       = r_held;
        n_written    = 1'b0;

        if (i_mode == lsbb_pkg::MODE_STATUS) begin
            n_status = i_status_code;
            n_tick   = '0;
            if (i_status_code inside {[lsbb_pkg::ST_IDLE:lsbb_pkg::ST_WORKING]}) begin
                n_effect = lsbb_pkg::FX_BLINK;
            end else if (i_status_code == lsbb_pkg::ST_SLEEPING) begin
                n_effect     = lsbb_pkg::FX_BREATHE;
                n_held       = '0;
                n_written    = 1'b1;
                n_ramp_level = adv_level;
                n_ramp_rise  = adv_rise;
            end else begin
                n_effect = lsbb_pkg::FX_NONE;
            end
        end else begin
            case (r_effect)
                lsbb_pkg::FX_BLINK: begin
                    n_tick = tick_fire ? '0 : tick_inc;
                    if (tick_fire) begin
                        n_lit     = !r_lit;
                        n_held    = !r_lit ? lsbb_pkg::DUTY_OUT_W'(EXT_W'(blink_duty)) : '0;
                        n_written = 1'b1;
                    end
                end
                lsbb_pkg::FX_BREATHE: begin
                    n_tick = tick_fire ? '0 : tick_inc;
                    if (tick_fire) begin
                        n_held       = lsbb_pkg::DUTY_OUT_W'(EXT_W'(r_ramp_level));
                        n_written    = 1'b1;
                        n_ramp_level = adv_level;
                        n_ramp_rise  = adv_rise;
                    end
                end
                default: ;
            endcase
        end
    end

    // state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status     <= lsbb_pkg::ST_IDLE;
            r_effect     <= lsbb_pkg::FX_NONE;
            r_lit        <= 1'b0;
            r_tick       <= '0;
            r_ramp_level <= '0;
            r_ramp_rise  <= 1'b1;
            r_held       <= '0;
            r_written    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_status     <= n_status;
                r_effect     <= n_effect;
                r_lit        <= n_lit;
                r_tick       <= n_tick;
                r_ramp_level <= n_ramp_level;
                r_ramp_rise  <= n_ramp_rise;
                r_held       <= n_held;
                r_written    <= n_written;
                r_out_valid  <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire
